FILE: hdl/fctp_pkg.sv
// ----------------------------------------------------------------------------
// fctp_pkg
// Shared types and codes for the flash command tag pool: item layouts,
// operation codes, completion codes and status codes.
// ----------------------------------------------------------------------------
package fctp_pkg;

    // bus field and the number of tag groups it can name
    localparam int BUS_W     = 3;
    localparam int NUM_BUSES = 8;

    // operation codes
    localparam logic [1:0] OP_ERASE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;
    localparam logic [1:0] OP_EVENT = 2'd3;

    // completion event codes
    localparam logic [7:0] EV_READ_DONE   = 8'd0;
    localparam logic [7:0] EV_WRITE_DONE  = 8'd1;
    localparam logic [7:0] EV_ERASE_DONE  = 8'd2;
    localparam logic [7:0] EV_ERASE_FAIL  = 8'd3;
    localparam logic [7:0] EV_WRITE_READY = 8'd4;

    // reported event status
    localparam logic [2:0] ST_NONE        = 3'd0;
    localparam logic [2:0] ST_PAGE_DONE   = 3'd1;
    localparam logic [2:0] ST_ERASE_DONE  = 3'd2;
    localparam logic [2:0] ST_ERASE_FAIL  = 3'd3;
    localparam logic [2:0] ST_WRITE_READY = 3'd4;
    localparam logic [2:0] ST_UNKNOWN     = 3'd5;

    // request or completion event item
    typedef struct packed {
        logic [1:0]       operation;
        logic [BUS_W-1:0] bus;
        logic [7:0]       chip;
        logic [15:0]      block;
        logic [7:0]       page;
        logic [7:0]       target;
        logic [6:0]       event_tag;
        logic [7:0]       event_code;
    } t_in_item;

    // result item
    typedef struct packed {
        logic        accepted;
        logic [6:0]  tag;
        logic [1:0]  cmd_opcode;
        logic [31:0] cmd_address;
        logic [23:0] cmd_tag_word;
        logic [2:0]  event_status;
        logic        copy_to_host;
    } t_out_item;

endpackage

FILE: hdl/fctp_busy_store.sv
// ----------------------------------------------------------------------------
// fctp_busy_store
// Busy flags, one row of TAGS_PER_BUS bits per bus, in a synchronous memory
// with a registered read. Per-row valid bits make never-written rows read idle;
// a write to the row being read in the same cycle is forwarded.
// ----------------------------------------------------------------------------
module fctp_busy_store
    import fctp_pkg::*;
#(
    parameter int TAGS_PER_BUS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_rd_en,
    input  logic [BUS_W-1:0]        i_rd_row,
    output logic [TAGS_PER_BUS-1:0] o_rd_data,
    input  logic                    i_wr_en,
    input  logic [BUS_W-1:0]        i_wr_row,
    input  logic [TAGS_PER_BUS-1:0] i_wr_data
);

    logic [TAGS_PER_BUS-1:0] r_mem [NUM_BUSES];
    logic [NUM_BUSES-1:0]    r_row_vld;
    logic [TAGS_PER_BUS-1:0] r_rd_raw;
    logic                    r_rd_vld;
    logic                    r_fwd_en;
    logic [TAGS_PER_BUS-1:0] r_fwd_data;

    // memory write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_row] <= i_wr_data;
        end
    end

    // memory read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_raw   <= r_mem[i_rd_row];
            r_fwd_data <= i_wr_data;
        end
    end

    // row valid bits and forwarding control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_rd_vld  <= 1'b0;
            r_fwd_en  <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_row_vld[i_wr_row] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_row_vld[i_rd_row];
                r_fwd_en <= i_wr_en && (i_wr_row == i_rd_row);
            end
        end
    end

    // forwarded data wins, an unwritten row reads all idle
    assign o_rd_data = r_fwd_en ? r_fwd_data : (r_rd_vld ? r_rd_raw : '0);

endmodule

FILE: hdl/fctp_target_store.sv
// ----------------------------------------------------------------------------
// fctp_target_store
// Read target per tag in a synchronous memory with a registered read. A write
// to the entry read in the same cycle is forwarded.
// ----------------------------------------------------------------------------
module fctp_target_store #(
    parameter int NUM_TAGS = 128,
    localparam int TW      = $clog2(NUM_TAGS)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_rd_en,
    input  logic [TW-1:0] i_rd_addr,
    output logic [7:0]    o_rd_data,
    input  logic          i_wr_en,
    input  logic [TW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data
);

    logic [7:0] r_mem [NUM_TAGS];
    logic [7:0] r_rd_raw;
    logic [7:0] r_fwd_data;
    logic       r_fwd_en;

    // memory write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // memory read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_raw   <= r_mem[i_rd_addr];
            r_fwd_data <= i_wr_data;
        end
    end

    // same-entry forwarding flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_en <= 1'b0;
        end else if (i_rd_en) begin
            r_fwd_en <= i_wr_en && (i_wr_addr == i_rd_addr);
        end
    end

    assign o_rd_data = r_fwd_en ? r_fwd_data : r_rd_raw;

endmodule

FILE: hdl/fctp_first_free.sv
// ----------------------------------------------------------------------------
// fctp_first_free
// Lowest idle slot of one bus's tag group. Slots whose tag number falls
// beyond the pool never count as idle.
// ----------------------------------------------------------------------------
module fctp_first_free
    import fctp_pkg::*;
#(
    parameter int TAGS_PER_BUS = 16,
    parameter int NUM_TAGS     = 128,
    localparam int CW          = $clog2(TAGS_PER_BUS)
) (
    input  logic [TAGS_PER_BUS-1:0] i_busy_row,
    input  logic [BUS_W-1:0]        i_bus,
    output logic                    o_found,
    output logic [CW-1:0]           o_col
);

    logic [31:0]             w_base;
    logic [TAGS_PER_BUS-1:0] w_avail;

    assign w_base = 32'(i_bus) * 32'(TAGS_PER_BUS);

    // idle and inside the pool
    always_comb begin
        for (int i = 0; i < TAGS_PER_BUS; i++) begin
            w_avail[i] = !i_busy_row[i] && ((w_base + 32'(i)) < 32'(NUM_TAGS));
        end
    end

    // priority encode, lowest slot first
    always_comb begin
        o_found = 1'b0;
        o_col   = '0;
        for (int i = TAGS_PER_BUS - 1; i >= 0; i--) begin
            if (w_avail[i]) begin
                o_found = 1'b1;
                o_col   = CW'(i);
            end
        end
    end

endmodule

FILE: hdl/flash_command_tag_pool_core.sv
// ----------------------------------------------------------------------------
// flash_command_tag_pool_core
// Flash command tag pool: allocates the lowest idle tag of a bus for erase,
// read and write requests and frees tags on done and fail completion events.
// ----------------------------------------------------------------------------
// The block takes one item per cycle while the output side is ready and
// returns one result item for every item. Busy flags live in a memory of
// one row per bus with a registered read: the row is read when an item is
// accepted, searched for the lowest idle slot and written back as the item
// leaves the work stage, and a row written back while the next item reads
// it is forwarded, so back-to-back items on one bus see each other's effect.
// Read targets live in a second memory indexed by tag. Per-row valid bits
// make every tag idle right after reset, so no clearing pass is needed. A
// request on a bus with no idle tag is rejected with an all-zero result.
// ----------------------------------------------------------------------------
module flash_command_tag_pool_core
    import fctp_pkg::*;
#(
    parameter int TAGS_PER_BUS = 16,
    parameter int NUM_TAGS     = 128
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    localparam int CW = $clog2(TAGS_PER_BUS);
    localparam int TW = $clog2(NUM_TAGS);

    // input side
    logic             w_in_acc;
    logic             w_in_evt;
    logic [31:0]      w_in_etag32;
    logic             w_in_erow_hit;
    logic [BUS_W-1:0] w_in_erow;
    logic [CW-1:0]    w_in_ecol;
    logic [BUS_W-1:0] w_rd_row;

    // work stage
    logic             r_s1_vld;
    t_in_item         r_s1_item;
    logic             r_s1_erow_hit;
    logic [BUS_W-1:0] r_s1_row;
    logic [CW-1:0]    r_s1_ecol;
    logic             w_s1_adv;
    logic             w_s1_evt;

    // memory ports
    logic [TAGS_PER_BUS-1:0] w_busy_row;
    logic                    w_bwr_en;
    logic [TAGS_PER_BUS-1:0] w_bwr_data;
    logic [7:0]              w_tgt_rd;
    logic                    w_twr_en;

    // allocation and event decode
    logic                    w_found;
    logic [CW-1:0]           w_ff_col;
    logic [CW-1:0]           w_col;
    logic [TAGS_PER_BUS-1:0] w_col_bit;
    logic [31:0]             w_tg32;
    logic [31:0]             w_etag32;
    logic                    w_in_pool;
    logic                    w_frees;
    logic [2:0]              w_status;
    t_out_item               n_out_item;

    // output register
    logic      r_out_vld;
    t_out_item r_out_item;

    // ------------------------------------------------------------------
    // accept and issue memory reads
    // ------------------------------------------------------------------
    assign w_s1_adv   = r_s1_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_s1_vld || w_s1_adv;
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_in_evt   = (i_in_item.operation == OP_EVENT);
    assign w_in_etag32 = 32'(i_in_item.event_tag);

    // locate the event tag's bus row and slot
    always_comb begin
        w_in_erow_hit = 1'b0;
        w_in_erow     = '0;
        w_in_ecol     = '0;
        for (int b = 0; b < NUM_BUSES; b++) begin
            if (w_in_etag32 >= 32'(b * TAGS_PER_BUS) &&
                w_in_etag32 < 32'((b + 1) * TAGS_PER_BUS)) begin
                w_in_erow_hit = 1'b1;
                w_in_erow     = BUS_W'(b);
                w_in_ecol     = CW'(w_in_etag32 - 32'(b * TAGS_PER_BUS));
            end
        end
    end

    assign w_rd_row = w_in_evt ? w_in_erow : i_in_item.bus;

    // ------------------------------------------------------------------
    // work stage registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_in_acc) begin
            r_s1_vld <= 1'b1;
        end else if (w_s1_adv) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_item     <= i_in_item;
            r_s1_erow_hit <= w_in_erow_hit;
            r_s1_row      <= w_rd_row;
            r_s1_ecol     <= w_in_ecol;
        end
    end

    // ------------------------------------------------------------------
    // state memories
    // ------------------------------------------------------------------
    fctp_busy_store #(
        .TAGS_PER_BUS (TAGS_PER_BUS)
    ) u_busy (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_in_acc),
        .i_rd_row  (w_rd_row),
        .o_rd_data (w_busy_row),
        .i_wr_en   (w_bwr_en),
        .i_wr_row  (r_s1_row),
        .i_wr_data (w_bwr_data)
    );

    fctp_target_store #(
        .NUM_TAGS (NUM_TAGS)
    ) u_target (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_in_acc && w_in_evt),
        .i_rd_addr (w_in_etag32[TW-1:0]),
        .o_rd_data (w_tgt_rd),
        .i_wr_en   (w_twr_en),
        .i_wr_addr (w_tg32[TW-1:0]),
        .i_wr_data (r_s1_item.target)
    );

    // ------------------------------------------------------------------
    // allocate or free
    // ------------------------------------------------------------------
    fctp_first_free #(
        .TAGS_PER_BUS (TAGS_PER_BUS),
        .NUM_TAGS     (NUM_TAGS)
    ) u_first_free (
        .i_busy_row (w_busy_row),
        .i_bus      (r_s1_item.bus),
        .o_found    (w_found),
        .o_col      (w_ff_col)
    );

    assign w_s1_evt  = (r_s1_item.operation == OP_EVENT);
    assign w_col     = w_s1_evt ? r_s1_ecol : w_ff_col;
    assign w_col_bit = {{(TAGS_PER_BUS - 1){1'b0}}, 1'b1} << w_col;
    assign w_tg32    = 32'(r_s1_item.bus) * 32'(TAGS_PER_BUS) + 32'(w_ff_col);
    assign w_etag32  = 32'(r_s1_item.event_tag);
    assign w_in_pool = w_etag32 < 32'(NUM_TAGS);

    // event status per completion code
    always_comb begin
        w_frees = 1'b0;
        case (r_s1_item.event_code)
            EV_READ_DONE: begin
                w_status = ST_PAGE_DONE;
                w_frees  = 1'b1;
            end
            EV_WRITE_DONE: begin
                w_status = ST_PAGE_DONE;
                w_frees  = 1'b1;
            end
            EV_ERASE_DONE: begin
                w_status = ST_ERASE_DONE;
                w_frees  = 1'b1;
            end
            EV_ERASE_FAIL: begin
                w_status = ST_ERASE_FAIL;
                w_frees  = 1'b1;
            end
            EV_WRITE_READY: begin
                w_status = ST_WRITE_READY;
            end
            default: begin
                w_status = ST_UNKNOWN;
            end
        endcase
    end

    // write-back of the busy row and the read target
    always_comb begin
        w_bwr_en   = 1'b0;
        w_bwr_data = w_busy_row;
        if (w_s1_evt) begin
            w_bwr_en   = w_s1_adv && w_frees && w_in_pool && r_s1_erow_hit;
            w_bwr_data = w_busy_row & ~w_col_bit;
        end else begin
            w_bwr_en   = w_s1_adv && w_found;
            w_bwr_data = w_busy_row | w_col_bit;
        end
    end

    assign w_twr_en = w_s1_adv && !w_s1_evt && w_found &&
                      (r_s1_item.operation == OP_READ);

    // result item
    always_comb begin
        n_out_item = '0;
        if (w_s1_evt) begin
            n_out_item.tag          = r_s1_item.event_tag;
            n_out_item.event_status = w_status;
            n_out_item.copy_to_host = (r_s1_item.event_code == EV_READ_DONE) &&
                                      w_in_pool && (w_tgt_rd == 8'd0);
        end else if (w_found) begin
            n_out_item.accepted    = 1'b1;
            n_out_item.tag         = w_tg32[6:0];
            n_out_item.cmd_opcode  = r_s1_item.operation;
            n_out_item.cmd_address = {r_s1_item.block,
                                      (r_s1_item.operation == OP_ERASE) ?
                                          8'd0 : r_s1_item.page,
                                      r_s1_item.chip};
            if (r_s1_item.operation == OP_READ) begin
                n_out_item.cmd_tag_word = {r_s1_item.target, w_tg32[15:0]};
            end else begin
                n_out_item.cmd_tag_word = {8'd0, w_tg32[15:0]};
            end
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_s1_adv) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out_item;

`ifndef NO_ASSERTIONS
    // a granted tag lies in the requested bus's group and inside the pool
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s1_adv && !w_s1_evt && w_found) |->
            (w_tg32 >= 32'(r_s1_item.bus) * 32'(TAGS_PER_BUS)) &&
            (w_tg32 < 32'(NUM_TAGS)))
        else $error("granted tag outside its bus group");

    // a granted request carries no event status
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.accepted) |->
            (o_out_item.event_status == ST_NONE) && !o_out_item.copy_to_host &&
            (o_out_item.cmd_opcode != OP_EVENT))
        else $error("granted request with event fields set");

    // host copy only on a page-done status
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.copy_to_host) |->
            (o_out_item.event_status == ST_PAGE_DONE) && !o_out_item.accepted)
        else $error("host copy without page done");
`endif

endmodule

FILE: tb/sv/flash_command_tag_pool_checker.sv
// ----------------------------------------------------------------------------
// flash_command_tag_pool_checker
// Watches both channels of the tag pool, keeps its own copy of the busy flags
// and read targets, works out the result of every accepted item and compares
// each returned result field by field, in order.
// ----------------------------------------------------------------------------
module flash_command_tag_pool_checker
    import fctp_pkg::*;
#(
    parameter int TAGS_PER_BUS = 16,
    parameter int NUM_TAGS     = 128
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  t_in_item            i_in_item,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  t_out_item           i_out_item,
    output int                  o_fail_count,
    output int                  o_pending,
    output int                  o_checked,
    output int                  o_commands,
    output int                  o_rejects,
    output int                  o_events,
    output int                  o_copies,
    output logic [NUM_TAGS-1:0] o_tag_busy,
    output logic [NUM_TAGS-1:0] o_target_set
);
    timeunit 1ns;
    timeprecision 1ps;

    // read destination recorded per tag
    logic [7:0] read_target [NUM_TAGS];
    // outcomes still waiting for their result item
    t_out_item  outcome_q [$];
    t_out_item  want_item;
    t_out_item  new_outcome;

    // allocate the lowest idle tag of the bus or apply a completion event
    function automatic t_out_item tag_pool_outcome(input t_in_item it);
        t_out_item  res;
        int         slot;
        int         idx;
        logic       in_pool;
        logic       frees;
        logic [7:0] page_v;
        res  = '0;
        slot = -1;
        if (it.operation != OP_EVENT) begin
            for (int i = 0; i < TAGS_PER_BUS; i++) begin
                idx = int'(it.bus) * TAGS_PER_BUS + i;
                if (idx >= NUM_TAGS) break;
                if (!o_tag_busy[idx]) begin
                    slot = idx;
                    break;
                end
            end
            // no idle tag: all-zero result, nothing changes
            if (slot >= 0) begin
                page_v = (it.operation == OP_ERASE) ? 8'd0 : it.page;
                o_tag_busy[slot] = 1'b1;
                res.accepted     = 1'b1;
                res.tag          = 7'(slot);
                res.cmd_opcode   = it.operation;
                res.cmd_address  = {it.block, page_v, it.chip};
                res.cmd_tag_word = 24'(slot);
                if (it.operation == OP_READ) begin
                    read_target[slot]  = it.target;
                    o_target_set[slot] = 1'b1;
                    res.cmd_tag_word   = {it.target, 16'(slot)};
                end
            end
        end else begin
            in_pool = int'(it.event_tag) < NUM_TAGS;
            frees   = 1'b0;
            res.tag = it.event_tag;
            case (it.event_code)
                EV_READ_DONE: begin
                    res.event_status = ST_PAGE_DONE;
                    frees            = 1'b1;
                    if (in_pool)
                        res.copy_to_host = (read_target[it.event_tag] == 8'd0);
                end
                EV_WRITE_DONE: begin
                    res.event_status = ST_PAGE_DONE;
                    frees            = 1'b1;
                end
                EV_ERASE_DONE: begin
                    res.event_status = ST_ERASE_DONE;
                    frees            = 1'b1;
                end
                EV_ERASE_FAIL: begin
                    res.event_status = ST_ERASE_FAIL;
                    frees            = 1'b1;
                end
                EV_WRITE_READY: begin
                    // tag stays busy until the write completes
                    res.event_status = ST_WRITE_READY;
                end
                default: begin
                    res.event_status = ST_UNKNOWN;
                end
            endcase
            if (frees && in_pool)
                o_tag_busy[it.event_tag] = 1'b0;
        end
        return res;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want_v,
                                 input logic [31:0] got_v);
        if (want_v !== got_v) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want_v, got_v);
            o_fail_count++;
        end
    endtask

    // compare results, then queue the outcome of a newly accepted item
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_fail_count = 0;
            o_pending    = 0;
            o_checked    = 0;
            o_commands   = 0;
            o_rejects    = 0;
            o_events     = 0;
            o_copies     = 0;
            o_tag_busy   = '0;
            o_target_set = '0;
            outcome_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (outcome_q.size() == 0) begin
                    $error("result item with no outstanding item: tag 0x%0h",
                           i_out_item.tag);
                    o_fail_count++;
                end else begin
                    want_item = outcome_q.pop_front();
                    compare_field("accepted", 32'(want_item.accepted),
                                  32'(i_out_item.accepted));
                    compare_field("tag", 32'(want_item.tag), 32'(i_out_item.tag));
                    compare_field("cmd_opcode", 32'(want_item.cmd_opcode),
                                  32'(i_out_item.cmd_opcode));
                    compare_field("cmd_address", want_item.cmd_address,
                                  i_out_item.cmd_address);
                    compare_field("cmd_tag_word", 32'(want_item.cmd_tag_word),
                                  32'(i_out_item.cmd_tag_word));
                    compare_field("event_status", 32'(want_item.event_status),
                                  32'(i_out_item.event_status));
                    compare_field("copy_to_host", 32'(want_item.copy_to_host),
                                  32'(i_out_item.copy_to_host));
                    o_checked++;
                end
            end
            if (i_in_valid && i_in_ready) begin
                new_outcome = tag_pool_outcome(i_in_item);
                outcome_q.push_back(new_outcome);
                if (i_in_item.operation == OP_EVENT) begin
                    o_events++;
                    if (new_outcome.copy_to_host)
                        o_copies++;
                end else if (new_outcome.accepted) begin
                    o_commands++;
                end else begin
                    o_rejects++;
                end
            end
            o_pending = outcome_q.size();
        end
    end

endmodule

FILE: tb/sv/tb_flash_command_tag_pool_core.sv
// ----------------------------------------------------------------------------
// tb_flash_command_tag_pool_core
// Drives requests and completion events into the tag pool: a directed
// opening (field extremes, every event code, a full bus and its rejection),
// then random bursts that keep tags cycling through busy and idle, with a
// stalling receiver. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_flash_command_tag_pool_core
    import fctp_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TAGS_PER_BUS = 16;
    localparam int NUM_TAGS     = 128;
    localparam int RANDOM_ITEMS = 1600;
    localparam int CYCLE_LIMIT  = 250000;
    localparam int DRAIN_CYCLES = 10;

    localparam logic [1:0] REQUEST_OPS [3] = '{OP_ERASE, OP_READ, OP_WRITE};
    localparam logic [7:0] EV_FIRST_UNKNOWN = EV_WRITE_READY + 8'd1;
    localparam logic [7:0] EV_LAST_UNKNOWN  = 8'hff;

    logic          i_clk;
    logic          i_rst_n     = 1'b0;
    logic          i_in_valid  = 1'b0;
    logic          o_in_ready;
    t_in_item      in_item     = '0;
    logic          o_out_valid;
    logic          i_out_ready = 1'b0;
    t_out_item     out_item;

    int                  fail_count;
    int                  pending;
    int                  checked;
    int                  commands;
    int                  rejects;
    int                  events_seen;
    int                  copies;
    logic [NUM_TAGS-1:0] tag_busy;
    logic [NUM_TAGS-1:0] target_set;

    int cycle_count = 0;
    int stall_mode  = 0;
    int mode_left   = 0;

    flash_command_tag_pool_core #(
        .TAGS_PER_BUS (TAGS_PER_BUS),
        .NUM_TAGS     (NUM_TAGS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (out_item)
    );

    flash_command_tag_pool_checker #(
        .TAGS_PER_BUS (TAGS_PER_BUS),
        .NUM_TAGS     (NUM_TAGS)
    ) tag_pool_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_item    (in_item),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_item   (out_item),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_commands   (commands),
        .o_rejects    (rejects),
        .o_events     (events_seen),
        .o_copies     (copies),
        .o_tag_busy   (tag_busy),
        .o_target_set (target_set)
    );

    // 8 ns clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // receiver stalls, switching between random stall patterns
    always @(negedge i_clk) begin
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(40, 200);
        end
        mode_left--;
        case (stall_mode)
            0: i_out_ready <= 1'b1;
            1: i_out_ready <= 1'($urandom_range(0, 1));
            2: i_out_ready <= ($urandom_range(0, 9) != 0);
            default: i_out_ready <= (mode_left % 5 == 0);
        endcase
    end

    function automatic t_in_item request_item(input logic [1:0] op, input logic [2:0] bus,
                                              input logic [7:0] chip,
                                              input logic [15:0] block,
                                              input logic [7:0] page,
                                              input logic [7:0] target);
        t_in_item it;
        it           = '0;
        it.operation = op;
        it.bus       = bus;
        it.chip      = chip;
        it.block     = block;
        it.page      = page;
        it.target    = target;
        return it;
    endfunction

    function automatic t_in_item event_item(input logic [6:0] tag, input logic [7:0] code);
        t_in_item it;
        it            = '0;
        it.operation  = OP_EVENT;
        it.event_tag  = tag;
        it.event_code = code;
        return it;
    endfunction

    // present one item from a falling edge and hold it until accepted
    task automatic send_item(input t_in_item it);
        i_in_valid <= 1'b1;
        in_item    <= it;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    // random request or event, steered by the current busy flags
    task automatic random_item(input logic [2:0] hot_bus, output t_in_item it);
        logic [63:0] raw;
        int          busy_list [$];
        int          pick;
        int          req_pct;
        raw     = {$urandom, $urandom};
        it      = raw[$bits(t_in_item)-1:0];
        req_pct = ($countones(tag_busy) > 80) ? 35 : 60;
        if ($urandom_range(0, 99) < req_pct) begin
            it.operation = REQUEST_OPS[$urandom_range(0, 2)];
            if ($urandom_range(0, 99) < 60)
                it.bus = hot_bus;
            if ($urandom_range(0, 3) == 0)
                it.target = 8'd0;
        end else begin
            it.operation = OP_EVENT;
            for (int t = 0; t < NUM_TAGS; t++)
                if (tag_busy[t])
                    busy_list.push_back(t);
            if (busy_list.size() > 0 && $urandom_range(0, 9) != 0)
                it.event_tag = 7'(busy_list[$urandom_range(0, busy_list.size() - 1)]);
            pick = $urandom_range(0, 99);
            if (pick < 30)
                it.event_code = EV_READ_DONE;
            else if (pick < 50)
                it.event_code = EV_WRITE_DONE;
            else if (pick < 65)
                it.event_code = EV_ERASE_DONE;
            else if (pick < 75)
                it.event_code = EV_ERASE_FAIL;
            else if (pick < 90)
                it.event_code = EV_WRITE_READY;
            else
                it.event_code = 8'($urandom_range(EV_FIRST_UNKNOWN, EV_LAST_UNKNOWN));
            // a read done must name a tag whose target was recorded
            if (it.event_code == EV_READ_DONE && !target_set[it.event_tag])
                it.event_code = EV_WRITE_DONE;
        end
    endtask

    initial begin
        t_in_item   it;
        logic [2:0] hot_bus;
        int         sent;
        int         burst;
        int         gap;

        // reset
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reads at both extremes, write ready keeps the tag, read done with
        // and without host copy
        send_item(request_item(OP_READ, 3'd0, 8'h00, 16'h0000, 8'h00, 8'h00));
        send_item(request_item(OP_READ, 3'd0, 8'hff, 16'hffff, 8'hff, 8'hff));
        send_item(event_item(7'd1, EV_WRITE_READY));
        send_item(event_item(7'd0, EV_READ_DONE));
        send_item(event_item(7'd1, EV_READ_DONE));

        // fill the last bus with mixed requests, then one more is rejected
        for (int i = 0; i < TAGS_PER_BUS; i++)
            send_item(request_item(REQUEST_OPS[i % 3], 3'd7, 8'(i * 17),
                                   i[0] ? 16'hffff : 16'h0000, 8'ha5,
                                   (i == 1) ? 8'h00 : 8'(8'hff - i)));
        send_item(request_item(OP_WRITE, 3'd7, 8'h5a, 16'h1234, 8'h3c, 8'h00));

        // remaining completion codes, including unknown ones
        send_item(event_item(7'd127, EV_ERASE_FAIL));
        send_item(event_item(7'd112, EV_ERASE_DONE));
        send_item(event_item(7'd113, EV_WRITE_DONE));
        send_item(event_item(7'd64, EV_FIRST_UNKNOWN));
        send_item(event_item(7'd127, EV_LAST_UNKNOWN));

        // random bursts with gaps between them
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            hot_bus = 3'($urandom_range(0, NUM_BUSES - 1));
            burst   = $urandom_range(1, 24);
            for (int b = 0; b < burst && sent < RANDOM_ITEMS; b++) begin
                random_item(hot_bus, it);
                send_item(it);
                sent++;
            end
            gap = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 8) : 0;
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        i_in_valid <= 1'b0;

        // drain outstanding results
        while (pending != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("checked %0d results: %0d commands issued, %0d requests turned away",
                 checked, commands, rejects);
        $display("%0d completion events, %0d of them with a copy to the host buffer",
                 events_seen, copies);
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/fctp_pkg.sv
hdl/fctp_busy_store.sv
hdl/fctp_target_store.sv
hdl/fctp_first_free.sv
hdl/flash_command_tag_pool_core.sv
tb/sv/flash_command_tag_pool_checker.sv
tb/sv/tb_flash_command_tag_pool_core.sv
